@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, transaction types, sequencer states and saturating
// arithmetic for the sample covariance accumulator.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_PARAMS = 16;
    localparam int IDX_W      = $clog2(MAX_PARAMS);
    localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
    localparam int CFG_W      = 5;
    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int ITER_W     = $clog2(DATA_W + 1);

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_READ     = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ELEMENT = 1'b0,
        REQ_READ    = 1'b1
    } req_t;

    typedef struct packed {
        req_t               req_type;
        logic signed [31:0] energy;
        logic signed [31:0] derivative;
        logic               last_element;
        logic [3:0]         row;
        logic [3:0]         col;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        samples_seen;
        logic signed [63:0] energy_average;
        logic signed [63:0] derivative_average;
        logic signed [63:0] covariance_entry;
        logic signed [63:0] force_value;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_INIT,
        ST_ACC_RD_I,
        ST_ACC_LD_I,
        ST_ACC_WR_I,
        ST_ACC_RD_J,
        ST_ACC_MUL_J,
        ST_ACC_WR_J,
        ST_RD_ADDR,
        ST_RD_ROW,
        ST_RD_COL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FIN,
        ST_EMIT
    } state_t;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    function automatic logic signed [63:0] sat66(input logic signed [65:0] v);
        logic signed [63:0] r;
        if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            r = S64_MAX;
        end
        else if (v < -66'sh0_8000_0000_0000_0000)
        begin
            r = S64_MIN;
        end
        else
        begin
            r = v[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [65:0] s;
        s = $signed({{2{a[63]}}, a}) + $signed({{2{b[63]}}, b});
        return sat66(s);
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [65:0] s;
        s = $signed({{2{a[63]}}, a}) - $signed({{2{b[63]}}, b});
        return sat66(s);
    endfunction

    // saturating multiply by -2
    function automatic logic signed [63:0] neg2(input logic signed [63:0] x);
        logic signed [65:0] s;
        s = 66'sd0 - $signed({x[63], x, 1'b0});
        return sat66(s);
    endfunction

    function automatic logic signed [63:0] sext32(input logic [31:0] v);
        return $signed({{32{v[31]}}, v});
    endfunction

endpackage

@@ rtl/scc_ram.sv @@
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/scc_div.sv @@
// ----------------------------------------------------------------------------
// scc_div
// Signed 64-bit by unsigned 32-bit divider, truncating toward zero.
// Restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [scc_pkg::ITER_W-1:0] cnt_reg;
    logic                       done_reg;
    logic [63:0]                quo_reg;
    logic [31:0]                rem_reg;
    logic [31:0]                dvs_reg;
    logic                       neg_reg;
    logic [32:0]                rem_sh;
    logic                       ge;
    logic [32:0]                rem_next;
    logic [63:0]                mag;

    assign mag      = dividend[63] ? 64'd0 - dividend : dividend;
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == scc_pkg::ITER_W'(1));
            if (start)
            begin
                cnt_reg <= scc_pkg::ITER_W'(scc_pkg::DATA_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - scc_pkg::ITER_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(64'd0 - quo_reg) : $signed(quo_reg);

endmodule

@@ rtl/scc_mul.sv @@
// ----------------------------------------------------------------------------
// scc_mul
// Saturating signed 64 x 64 multiplier. Four 32 x 32 partial products,
// one per cycle, into a 128-bit accumulator.
// ----------------------------------------------------------------------------
module scc_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] product
);

    logic         run_reg;
    logic         done_reg;
    logic [1:0]   k_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_h;
    logic [31:0]  b_h;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  lim;
    logic         over;

    assign a_h = k_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_h = k_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp  = a_h * b_h;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= run_reg && (k_reg == 2'd3);
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'd0 - a : a;
            mb_reg  <= b[63] ? 64'd0 - b : b;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign lim  = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    assign over = (acc_reg[127:64] != '0) || (acc_reg[63:0] > lim);

    always_comb
    begin
        if (over)
        begin
            product = neg_reg ? scc_pkg::S64_MIN : scc_pkg::S64_MAX;
        end
        else
        begin
            product = neg_reg ? $signed(64'd0 - acc_reg[63:0]) : $signed(acc_reg[63:0]);
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/sr_covariance_accumulator.sv @@
// ----------------------------------------------------------------------------
// sr_covariance_accumulator
// Accumulates energy and derivative statistics of samples and answers read
// requests with means, one covariance entry and one force component.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low; a non-final element
// produces no result. A final element of the right length starts the update
// of the sums, holding busy high until all param_count derivatives and
// their outer products are in; each outer-product entry is a read, multiply
// and write back through the sums memory. A rejected sample gives its result
// in the next cycle without raising busy. A read request runs the bit-serial
// divider for up to five quotients and then the multiplier for up to two
// saturating products. Results appear on result for exactly one cycle with
// done high and must be taken then: there is no back-pressure.
// The configuration register may be written at any cycle.
// ----------------------------------------------------------------------------
module sr_covariance_accumulator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  scc_pkg::cmd_t              cmd,
    output logic                       done,
    output scc_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [scc_pkg::CFG_W-1:0]  cfg_data
);

    localparam int IW = scc_pkg::IDX_W;
    localparam int OW = 2 * scc_pkg::IDX_W;

    scc_pkg::state_t state_reg, state_next;

    logic [scc_pkg::CFG_W-1:0] param_count_reg;
    logic [31:0]               sample_total_reg;
    logic signed [63:0]        energy_total_reg;
    logic signed [31:0]        cur_energy_reg;
    logic [scc_pkg::CNT_W-1:0] pos_reg;
    logic                      len_err_reg;
    logic [IW-1:0]             last_reg;
    logic [IW-1:0]             i_reg;
    logic [IW-1:0]             j_reg;
    logic signed [31:0]        oi_reg;
    logic signed [63:0]        prod_reg;
    logic signed [63:0]        old_a_reg;
    logic signed [63:0]        old_b_reg;
    logic [IW-1:0]             row_reg;
    logic [IW-1:0]             col_reg;
    logic                      row_ok_reg;
    logic                      col_ok_reg;
    logic [scc_pkg::MAX_PARAMS-1:0]                    dv_vld_reg;
    logic [scc_pkg::MAX_PARAMS*scc_pkg::MAX_PARAMS-1:0] outer_vld_reg;
    logic                      dvq_reg;
    logic                      oq_reg;
    logic signed [63:0]        d_raw_reg, ed_raw_reg, dc_raw_reg, om_raw_reg;
    logic signed [63:0]        e_avg_reg, d_row_reg, ed_reg, d_col_reg, om_reg;
    logic signed [63:0]        t1_reg, t2_reg, diff_reg, cov_reg;
    logic [2:0]                k_reg;
    logic                      m_reg;
    logic                      done_reg;
    scc_pkg::result_t          result_reg;

    logic             take;
    logic             take_elem;
    logic             sample_ok;
    logic             emit;
    scc_pkg::status_t emit_status;

    logic          buf_we;
    logic [IW-1:0] buf_waddr, buf_raddr;
    logic [31:0]   buf_rdata;
    logic signed [31:0] buf_rs;
    logic          dv_we;
    logic [IW-1:0] dv_raddr;
    logic [127:0]  dv_wdata, dv_rdata;
    logic          outer_we;
    logic [OW-1:0] outer_waddr, outer_raddr;
    logic [63:0]   outer_wdata, outer_rdata;

    logic               div_start, div_done;
    logic signed [63:0] div_x, div_q;
    logic               mul_start, mul_done;
    logic signed [63:0] mul_a, mul_b, mul_p;

    assign take      = start && !busy;
    assign take_elem = take && (cmd.req_type == scc_pkg::REQ_ELEMENT);
    assign sample_ok = (pos_reg != scc_pkg::CNT_W'(scc_pkg::MAX_PARAMS)) && !len_err_reg
                       && (32'(pos_reg) + 32'd1 == 32'(param_count_reg));
    assign buf_rs    = $signed(buf_rdata);

    scc_ram #(.WIDTH(32), .DEPTH(scc_pkg::MAX_PARAMS)) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (cmd.derivative),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    scc_ram #(.WIDTH(128), .DEPTH(scc_pkg::MAX_PARAMS)) u_dv (
        .clk   (clk),
        .we    (dv_we),
        .waddr (i_reg),
        .wdata (dv_wdata),
        .raddr (dv_raddr),
        .rdata (dv_rdata)
    );

    scc_ram #(.WIDTH(64), .DEPTH(scc_pkg::MAX_PARAMS * scc_pkg::MAX_PARAMS)) u_outer (
        .clk   (clk),
        .we    (outer_we),
        .waddr (outer_waddr),
        .wdata (outer_wdata),
        .raddr (outer_raddr),
        .rdata (outer_rdata)
    );

    scc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_x),
        .divisor  (sample_total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    scc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.req_type == scc_pkg::REQ_READ)
                    begin
                        if (sample_total_reg != '0)
                        begin
                            state_next = scc_pkg::ST_RD_ADDR;
                        end
                    end
                    else if (cmd.last_element && sample_ok)
                    begin
                        state_next = scc_pkg::ST_ACC_INIT;
                    end
                end
            end
            scc_pkg::ST_ACC_INIT:  state_next = scc_pkg::ST_ACC_RD_I;
            scc_pkg::ST_ACC_RD_I:  state_next = scc_pkg::ST_ACC_LD_I;
            scc_pkg::ST_ACC_LD_I:  state_next = scc_pkg::ST_ACC_WR_I;
            scc_pkg::ST_ACC_WR_I:  state_next = scc_pkg::ST_ACC_RD_J;
            scc_pkg::ST_ACC_RD_J:  state_next = scc_pkg::ST_ACC_MUL_J;
            scc_pkg::ST_ACC_MUL_J: state_next = scc_pkg::ST_ACC_WR_J;
            scc_pkg::ST_ACC_WR_J:
            begin
                if (j_reg != last_reg)
                begin
                    state_next = scc_pkg::ST_ACC_RD_J;
                end
                else if (i_reg != last_reg)
                begin
                    state_next = scc_pkg::ST_ACC_RD_I;
                end
                else
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_RD_ADDR: state_next = scc_pkg::ST_RD_ROW;
            scc_pkg::ST_RD_ROW:  state_next = scc_pkg::ST_RD_COL;
            scc_pkg::ST_RD_COL:  state_next = scc_pkg::ST_DIV_GO;
            scc_pkg::ST_DIV_GO:  state_next = scc_pkg::ST_DIV_WAIT;
            scc_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (k_reg == 3'd0 && !row_ok_reg)
                    begin
                        state_next = scc_pkg::ST_EMIT;
                    end
                    else if ((k_reg == 3'd2 && !col_ok_reg) || k_reg == 3'd4)
                    begin
                        state_next = scc_pkg::ST_MUL_GO;
                    end
                    else
                    begin
                        state_next = scc_pkg::ST_DIV_GO;
                    end
                end
            end
            scc_pkg::ST_MUL_GO: state_next = scc_pkg::ST_MUL_WAIT;
            scc_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = m_reg ? scc_pkg::ST_FIN : scc_pkg::ST_MUL_GO;
                end
            end
            scc_pkg::ST_FIN:  state_next = scc_pkg::ST_EMIT;
            scc_pkg::ST_EMIT: state_next = scc_pkg::ST_IDLE;
            default:          state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        buf_we      = 1'b0;
        buf_waddr   = pos_reg[IW-1:0];
        buf_raddr   = i_reg;
        dv_we       = 1'b0;
        dv_raddr    = i_reg;
        outer_we    = 1'b0;
        outer_waddr = {i_reg, j_reg};
        outer_raddr = {i_reg, j_reg};
        div_start   = 1'b0;
        mul_start   = 1'b0;
        emit        = 1'b0;
        emit_status = scc_pkg::STATUS_READ;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                buf_we = take_elem && (pos_reg != scc_pkg::CNT_W'(scc_pkg::MAX_PARAMS));
                if (take)
                begin
                    if (cmd.req_type == scc_pkg::REQ_READ)
                    begin
                        emit = (sample_total_reg == '0);
                    end
                    else if (cmd.last_element && !sample_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = scc_pkg::STATUS_REJECTED;
                    end
                end
            end
            scc_pkg::ST_ACC_WR_I: dv_we = 1'b1;
            scc_pkg::ST_ACC_RD_J: buf_raddr = j_reg;
            scc_pkg::ST_ACC_WR_J:
            begin
                outer_we = 1'b1;
                if (j_reg == last_reg && i_reg == last_reg)
                begin
                    emit        = 1'b1;
                    emit_status = scc_pkg::STATUS_ACCEPTED;
                end
            end
            scc_pkg::ST_RD_ADDR:
            begin
                dv_raddr    = row_reg;
                outer_raddr = {row_reg, col_reg};
            end
            scc_pkg::ST_RD_ROW: dv_raddr = col_reg;
            scc_pkg::ST_DIV_GO: div_start = 1'b1;
            scc_pkg::ST_MUL_GO: mul_start = 1'b1;
            scc_pkg::ST_EMIT:   emit = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (k_reg)
            3'd0:    div_x = energy_total_reg;
            3'd1:    div_x = d_raw_reg;
            3'd2:    div_x = ed_raw_reg;
            3'd3:    div_x = dc_raw_reg;
            default: div_x = om_raw_reg;
        endcase
    end

    assign mul_a = m_reg ? d_row_reg : e_avg_reg;
    assign mul_b = m_reg ? d_col_reg : d_row_reg;

    assign dv_wdata    = {scc_pkg::sat_add(old_b_reg, prod_reg),
                          scc_pkg::sat_add(old_a_reg, scc_pkg::sext32(oi_reg))};
    assign outer_wdata = scc_pkg::sat_add(old_a_reg, prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= scc_pkg::ST_IDLE;
            param_count_reg  <= scc_pkg::CFG_W'(1);
            sample_total_reg <= '0;
            energy_total_reg <= '0;
            cur_energy_reg   <= '0;
            pos_reg          <= '0;
            len_err_reg      <= 1'b0;
            dv_vld_reg       <= '0;
            outer_vld_reg    <= '0;
            done_reg         <= 1'b0;
            k_reg            <= '0;
            m_reg            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (cfg_valid && cfg_ready)
            begin
                param_count_reg <= cfg_data;
            end
            if (take_elem)
            begin
                if (pos_reg == '0)
                begin
                    cur_energy_reg <= cmd.energy;
                end
                if (cmd.last_element)
                begin
                    pos_reg     <= '0;
                    len_err_reg <= 1'b0;
                end
                else if (pos_reg != scc_pkg::CNT_W'(scc_pkg::MAX_PARAMS))
                begin
                    pos_reg <= pos_reg + scc_pkg::CNT_W'(1);
                end
                else
                begin
                    len_err_reg <= 1'b1;
                end
            end
            if (state_reg == scc_pkg::ST_ACC_INIT)
            begin
                if (sample_total_reg != '1)
                begin
                    sample_total_reg <= sample_total_reg + 32'd1;
                end
                energy_total_reg <= scc_pkg::sat_add(energy_total_reg,
                                                     scc_pkg::sext32(cur_energy_reg));
            end
            if (state_reg == scc_pkg::ST_ACC_WR_I)
            begin
                dv_vld_reg[i_reg] <= 1'b1;
            end
            if (state_reg == scc_pkg::ST_ACC_WR_J)
            begin
                outer_vld_reg[{i_reg, j_reg}] <= 1'b1;
            end
            if (state_reg == scc_pkg::ST_RD_ADDR)
            begin
                k_reg <= '0;
                m_reg <= 1'b0;
            end
            if (state_reg == scc_pkg::ST_DIV_WAIT && div_done)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (state_reg == scc_pkg::ST_MUL_WAIT && mul_done)
            begin
                m_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvq_reg <= dv_vld_reg[dv_raddr];
        oq_reg  <= outer_vld_reg[outer_raddr];
        if (take_elem && cmd.last_element)
        begin
            last_reg <= pos_reg[IW-1:0];
        end
        if (take && cmd.req_type == scc_pkg::REQ_READ)
        begin
            row_reg    <= IW'(cmd.row);
            col_reg    <= IW'(cmd.col);
            row_ok_reg <= (32'(cmd.row) < 32'(param_count_reg))
                          && (32'(cmd.row) < scc_pkg::MAX_PARAMS);
            col_ok_reg <= (32'(cmd.col) < 32'(param_count_reg))
                          && (32'(cmd.col) < scc_pkg::MAX_PARAMS);
        end
        unique case (state_reg)
            scc_pkg::ST_ACC_INIT: i_reg <= '0;
            scc_pkg::ST_ACC_LD_I:
            begin
                oi_reg    <= buf_rs;
                prod_reg  <= cur_energy_reg * buf_rs;
                old_a_reg <= dvq_reg ? $signed(dv_rdata[63:0]) : 64'sd0;
                old_b_reg <= dvq_reg ? $signed(dv_rdata[127:64]) : 64'sd0;
            end
            scc_pkg::ST_ACC_WR_I: j_reg <= '0;
            scc_pkg::ST_ACC_MUL_J:
            begin
                prod_reg  <= oi_reg * buf_rs;
                old_a_reg <= oq_reg ? $signed(outer_rdata) : 64'sd0;
            end
            scc_pkg::ST_ACC_WR_J:
            begin
                if (j_reg != last_reg)
                begin
                    j_reg <= j_reg + IW'(1);
                end
                else
                begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            scc_pkg::ST_RD_ROW:
            begin
                d_raw_reg  <= dvq_reg ? $signed(dv_rdata[63:0]) : 64'sd0;
                ed_raw_reg <= dvq_reg ? $signed(dv_rdata[127:64]) : 64'sd0;
                om_raw_reg <= oq_reg ? $signed(outer_rdata) : 64'sd0;
            end
            scc_pkg::ST_RD_COL: dc_raw_reg <= dvq_reg ? $signed(dv_rdata[63:0]) : 64'sd0;
            scc_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (k_reg)
                        3'd0:    e_avg_reg <= div_q;
                        3'd1:    d_row_reg <= div_q;
                        3'd2:    ed_reg    <= div_q;
                        3'd3:    d_col_reg <= div_q;
                        default: om_reg    <= div_q;
                    endcase
                end
            end
            scc_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (m_reg)
                    begin
                        t2_reg <= mul_p;
                    end
                    else
                    begin
                        t1_reg <= mul_p;
                    end
                end
            end
            scc_pkg::ST_FIN:
            begin
                diff_reg <= scc_pkg::sat_sub(ed_reg, t1_reg);
                cov_reg  <= col_ok_reg ? scc_pkg::sat_sub(om_reg, t2_reg) : 64'sd0;
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            result_reg.status       <= emit_status;
            result_reg.samples_seen <= sample_total_reg;
            if (state_reg == scc_pkg::ST_EMIT)
            begin
                result_reg.energy_average <= e_avg_reg;
            end
            else
            begin
                result_reg.energy_average <= '0;
            end
            if (state_reg == scc_pkg::ST_EMIT && row_ok_reg)
            begin
                result_reg.derivative_average <= d_row_reg;
                result_reg.covariance_entry   <= cov_reg;
                result_reg.force_value        <= scc_pkg::neg2(diff_reg);
            end
            else
            begin
                result_reg.derivative_average <= '0;
                result_reg.covariance_entry   <= '0;
                result_reg.force_value        <= '0;
            end
        end
    end

    assign busy      = (state_reg != scc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

endmodule

@@ test/sr_covariance_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_covariance_accumulator_tb
// Drives sample elements and read requests into the accumulator under several
// param_count settings, with random gaps between transactions. A local model
// of the sums predicts every result, and the monitor compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sr_covariance_accumulator_tb;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    scc_pkg::cmd_t    cmd;
    logic             done;
    scc_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [4:0]       cfg_data;

    sr_covariance_accumulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    scc_pkg::cmd_t    pending_cmds[$];
    scc_pkg::result_t expected_results[$];
    int      fail_count;
    logic    taken;
    int      gap_left;
    bit      no_idle;

    // model of the sums
    logic [4:0] model_params;
    logic [31:0] model_count;
    longint     model_energy_sum;
    longint     model_deriv_sum[scc_pkg::MAX_PARAMS];
    longint     model_ed_sum[scc_pkg::MAX_PARAMS];
    longint     model_outer_sum[scc_pkg::MAX_PARAMS*scc_pkg::MAX_PARAMS];
    longint     model_buffer[scc_pkg::MAX_PARAMS];
    longint     model_cur_energy;
    int         model_pos;
    bit         model_len_err;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clamp66(logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (v < -66'sh0_8000_0000_0000_0000)
        begin
            return 64'h8000_0000_0000_0000;
        end
        return v[63:0];
    endfunction

    function automatic longint add_clamped(longint a, longint b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return clamp66(s);
    endfunction

    function automatic longint sub_clamped(longint a, longint b);
        logic signed [65:0] s;
        s = 66'(a) - 66'(b);
        return clamp66(s);
    endfunction

    function automatic longint mul_clamped(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        if (p > 128'sh7FFF_FFFF_FFFF_FFFF)
        begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (p < -128'sh8000_0000_0000_0000)
        begin
            return 64'h8000_0000_0000_0000;
        end
        return p[63:0];
    endfunction

    function automatic longint mean_of(longint x, logic [31:0] n);
        logic [63:0] mag;
        logic [63:0] q;
        if (n == 0)
        begin
            return 0;
        end
        mag = (x < 0) ? (64'd0 - 64'(x)) : 64'(x);
        q   = mag / {32'd0, n};
        return (x < 0) ? longint'(64'd0 - q) : longint'(q);
    endfunction

    function automatic void predict_cmd(scc_pkg::cmd_t c);
        scc_pkg::result_t r;
        longint  e_avg;
        longint  d_row;
        longint  d_col;
        longint  ed;
        longint  om;
        bit      row_ok;
        bit      col_ok;
        r = '0;
        if (c.req_type == scc_pkg::REQ_ELEMENT)
        begin
            if (model_pos == 0)
            begin
                model_cur_energy = longint'(c.energy);
            end
            if (model_pos < scc_pkg::MAX_PARAMS)
            begin
                model_buffer[model_pos] = longint'(c.derivative);
                model_pos++;
            end
            else
            begin
                model_len_err = 1'b1;
            end
            if (!c.last_element)
            begin
                return;
            end
            if (!model_len_err && model_params >= 1 && model_params <= scc_pkg::MAX_PARAMS &&
                model_pos == int'(model_params))
            begin
                if (model_count != 32'hFFFF_FFFF)
                begin
                    model_count++;
                end
                model_energy_sum = add_clamped(model_energy_sum, model_cur_energy);
                for (int i = 0; i < model_pos; i++)
                begin
                    model_deriv_sum[i] = add_clamped(model_deriv_sum[i], model_buffer[i]);
                    model_ed_sum[i] = add_clamped(model_ed_sum[i],
                                                  model_cur_energy * model_buffer[i]);
                    for (int j = 0; j < model_pos; j++)
                    begin
                        model_outer_sum[i*scc_pkg::MAX_PARAMS+j] =
                            add_clamped(model_outer_sum[i*scc_pkg::MAX_PARAMS+j],
                                        model_buffer[i] * model_buffer[j]);
                    end
                end
                r.status = scc_pkg::STATUS_ACCEPTED;
            end
            else
            begin
                r.status = scc_pkg::STATUS_REJECTED;
            end
            model_pos     = 0;
            model_len_err = 1'b0;
            r.samples_seen = model_count;
            expected_results.push_back(r);
            return;
        end
        r.status       = scc_pkg::STATUS_READ;
        r.samples_seen = model_count;
        if (model_count != 0)
        begin
            e_avg  = mean_of(model_energy_sum, model_count);
            row_ok = c.row < model_params;
            col_ok = c.col < model_params;
            r.energy_average = e_avg;
            if (row_ok)
            begin
                d_row = mean_of(model_deriv_sum[c.row], model_count);
                ed    = mean_of(model_ed_sum[c.row], model_count);
                r.derivative_average = d_row;
                r.force_value = mul_clamped(sub_clamped(ed, mul_clamped(e_avg, d_row)), -2);
                if (col_ok)
                begin
                    d_col = mean_of(model_deriv_sum[c.col], model_count);
                    om    = mean_of(model_outer_sum[c.row*scc_pkg::MAX_PARAMS+c.col],
                                    model_count);
                    r.covariance_entry = sub_clamped(om, mul_clamped(d_row, d_col));
                end
            end
        end
        expected_results.push_back(r);
    endfunction

    function automatic void compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // monitor: checks results, predicts accepted transactions
    always @(posedge clk)
    begin
        scc_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d", $time, result.status);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    compare_field("status", exp_r.status, result.status);
                    compare_field("samples_seen", exp_r.samples_seen, result.samples_seen);
                    compare_field("energy_average", exp_r.energy_average,
                                  result.energy_average);
                    compare_field("derivative_average", exp_r.derivative_average,
                                  result.derivative_average);
                    compare_field("covariance_entry", exp_r.covariance_entry,
                                  result.covariance_entry);
                    compare_field("force_value", exp_r.force_value, result.force_value);
                end
            end
            if (start && !busy)
            begin
                predict_cmd(cmd);
                taken <= 1'b1;
            end
            else
            begin
                taken <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                model_params = cfg_data;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !taken)
            begin
                start <= 1'b1;
            end
            else if (start && taken && gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (!start && gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd      <= pending_cmds.pop_front();
                start    <= 1'b1;
                gap_left = no_idle ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0)
                begin
                    no_idle = !no_idle;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] pick_value(int extreme_weight);
        int k;
        k = $urandom_range(0, 99);
        if (k < extreme_weight)
        begin
            return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (k < extreme_weight + 5)
        begin
            return 32'd0;
        end
        if (k < extreme_weight + 30)
        begin
            return 32'($signed($urandom_range(0, 262143)) - 131072);
        end
        return $urandom;
    endfunction

    function automatic void queue_sample(int len, int extreme_weight);
        scc_pkg::cmd_t c;
        for (int i = 0; i < len; i++)
        begin
            c.req_type     = scc_pkg::REQ_ELEMENT;
            c.energy       = pick_value(extreme_weight);
            c.derivative   = pick_value(extreme_weight);
            c.last_element = (i == len - 1);
            c.row          = 4'($urandom);
            c.col          = 4'($urandom);
            pending_cmds.push_back(c);
        end
    endfunction

    function automatic void queue_read(logic [3:0] r, logic [3:0] cl);
        scc_pkg::cmd_t c;
        c.req_type     = scc_pkg::REQ_READ;
        c.energy       = $urandom;
        c.derivative   = $urandom;
        c.last_element = 1'($urandom);
        c.row          = r;
        c.col          = cl;
        pending_cmds.push_back(c);
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_params(logic [4:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int items, int extreme_weight);
        int n;
        int len;
        n = 0;
        while (n < items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_read(4'($urandom), 4'($urandom));
                n++;
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    len = $urandom_range(1, 19);
                end
                else
                begin
                    len = (model_params >= 1 && model_params <= scc_pkg::MAX_PARAMS)
                          ? int'(model_params) : $urandom_range(1, 17);
                end
                queue_sample(len, extreme_weight);
                n += len;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        logic [4:0] settings[10] = '{5'd3, 5'd16, 5'd0, 5'd17, 5'd31,
                                     5'd2, 5'd8, 5'd1, 5'd16, 5'd5};
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        fail_count = 0;
        gap_left  = 0;
        no_idle   = 1'b0;
        taken     = 1'b0;
        rst_n     = 1'b0;
        model_params     = 5'd1;
        model_count      = 0;
        model_energy_sum = 0;
        model_cur_energy = 0;
        model_pos        = 0;
        model_len_err    = 1'b0;
        for (int i = 0; i < scc_pkg::MAX_PARAMS; i++)
        begin
            model_deriv_sum[i] = 0;
            model_ed_sum[i]    = 0;
            model_buffer[i]    = 0;
        end
        for (int i = 0; i < scc_pkg::MAX_PARAMS*scc_pkg::MAX_PARAMS; i++)
        begin
            model_outer_sum[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset setting of one element per sample
        queue_read(4'd0, 4'd0);
        queue_sample(1, 100);
        queue_sample(1, 100);
        queue_sample(1, 100);
        queue_read(4'd0, 4'd0);
        queue_read(4'd15, 4'd15);
        queue_read(4'd0, 4'd1);
        queue_sample(2, 50);
        queue_sample(17, 0);
        queue_read(4'd0, 4'd0);
        wait_idle();
        write_params(5'd4);
        queue_sample(2, 0);
        queue_read(4'd3, 4'd2);
        queue_sample(2, 0);
        queue_read(4'd3, 4'd3);
        queue_read(4'd4, 4'd0);
        wait_idle();

        foreach (settings[k])
        begin
            write_params(settings[k]);
            random_phase((settings[k] >= 1 && settings[k] <= scc_pkg::MAX_PARAMS) ? 210 : 60,
                         (k == 1 || k == 7) ? 60 : 8);
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_div.sv
rtl/scc_mul.sv
rtl/sr_covariance_accumulator.sv
test/sr_covariance_accumulator_tb.sv
